// ===== rtl/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, codes and the CRC-16/XMODEM byte update for the packet
// deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Header byte positions; bytes 0 and 1 are start bytes and are not checked.
  localparam logic [2:0] HDR_FIRST   = 3'd0;
  localparam logic [2:0] HDR_CTRL    = 3'd2;
  localparam logic [2:0] HDR_LEN_LO  = 3'd3;
  localparam logic [2:0] HDR_LEN_HI  = 3'd4;
  localparam logic [2:0] HDR_SEQ_LO  = 3'd5;
  localparam logic [2:0] HDR_SEQ_HI  = 3'd6;
  localparam logic [2:0] HDR_LAST    = 3'd7;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC     = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_STATUS  = 2'd1,
    KIND_TRUNC   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       datagram_end;
  } in_item_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  ctrl_field;
    logic [15:0] seq_number;
    logic [7:0]  cmd_code;
    logic [15:0] payload_length;
    logic        crc_match;
  } out_item_t;

  // Results produced by one accepted byte, first result in item0.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/cpd_parser.sv =====
// ----------------------------------------------------------------------------
// cpd_parser
// Frame state machine: captures the header, runs the CRC and produces up to
// two results for each accepted byte.
// ----------------------------------------------------------------------------
module cpd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  cpd_pkg::in_item_t in_item,
  output cpd_pkg::push_t    push
);

  cpd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]      idx_r, idx_nxt;
  logic [7:0]      ctrl_r, ctrl_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [15:0]     seq_r, seq_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [15:0]     pcount_r, pcount_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crc_lo_r, crc_lo_nxt;

  logic [7:0]  b;
  logic [15:0] pcount_inc;
  logic [15:0] crc_base;
  logic        trunc;
  logic        first_valid;
  cpd_pkg::out_item_t first_item, trunc_item;

  assign b          = in_item.rx_byte;
  assign pcount_inc = pcount_r + 16'd1;

  // Next state.
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    ctrl_nxt   = ctrl_r;
    len_nxt    = len_r;
    seq_nxt    = seq_r;
    cmd_nxt    = cmd_r;
    pcount_nxt = pcount_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    crc_base   = crc_r;
    trunc      = 1'b0;

    unique case (phase_r)
      cpd_pkg::PH_PAYLOAD: begin
        crc_nxt    = cpd_pkg::crc_update(crc_r, b);
        pcount_nxt = pcount_inc;
        if (pcount_inc >= len_r) begin
          phase_nxt = cpd_pkg::PH_CRC;
          idx_nxt   = cpd_pkg::HDR_FIRST;
        end
      end
      cpd_pkg::PH_CRC: begin
        if (idx_r == cpd_pkg::HDR_FIRST) begin
          crc_lo_nxt = b;
          idx_nxt    = 3'd1;
        end else begin
          phase_nxt  = cpd_pkg::PH_HEADER;
          idx_nxt    = cpd_pkg::HDR_FIRST;
          pcount_nxt = 16'd0;
          crc_nxt    = 16'd0;
          crc_lo_nxt = 8'd0;
        end
      end
      default: begin
        // The first header byte starts a new frame and clears what was held.
        if (idx_r == cpd_pkg::HDR_FIRST) begin
          ctrl_nxt   = 8'd0;
          len_nxt    = 16'd0;
          seq_nxt    = 16'd0;
          cmd_nxt    = 8'd0;
          pcount_nxt = 16'd0;
          crc_base   = 16'd0;
        end
        crc_nxt = cpd_pkg::crc_update(crc_base, b);
        case (idx_r)
          cpd_pkg::HDR_CTRL:   ctrl_nxt = b;
          cpd_pkg::HDR_LEN_LO: len_nxt  = {len_r[15:8], b};
          cpd_pkg::HDR_LEN_HI: len_nxt  = {b, len_r[7:0]};
          cpd_pkg::HDR_SEQ_LO: seq_nxt  = {seq_r[15:8], b};
          cpd_pkg::HDR_SEQ_HI: seq_nxt  = {b, seq_r[7:0]};
          cpd_pkg::HDR_LAST:   cmd_nxt  = b;
          default: ;
        endcase
        if (idx_r == cpd_pkg::HDR_LAST) begin
          idx_nxt    = cpd_pkg::HDR_FIRST;
          pcount_nxt = 16'd0;
          phase_nxt  = (len_r == 16'd0) ? cpd_pkg::PH_CRC : cpd_pkg::PH_PAYLOAD;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          phase_nxt = cpd_pkg::PH_HEADER;
        end
      end
    endcase

    // A datagram that ends anywhere but on a frame boundary truncates the frame.
    if (in_item.datagram_end &&
        !(phase_nxt == cpd_pkg::PH_HEADER && idx_nxt == cpd_pkg::HDR_FIRST)) begin
      trunc      = 1'b1;
      phase_nxt  = cpd_pkg::PH_HEADER;
      idx_nxt    = cpd_pkg::HDR_FIRST;
      pcount_nxt = 16'd0;
      crc_nxt    = 16'd0;
      crc_lo_nxt = 8'd0;
    end
  end

  // Result outputs.
  always_comb begin
    first_valid = 1'b0;
    first_item  = '{out_kind: cpd_pkg::KIND_PAYLOAD, payload_byte: 8'd0,
                    ctrl_field: ctrl_nxt, seq_number: seq_nxt, cmd_code: cmd_nxt,
                    payload_length: len_nxt, crc_match: 1'b0};
    trunc_item  = '{out_kind: cpd_pkg::KIND_TRUNC, payload_byte: 8'd0,
                    ctrl_field: ctrl_nxt, seq_number: seq_nxt, cmd_code: cmd_nxt,
                    payload_length: len_nxt, crc_match: 1'b0};
    unique case (phase_r)
      cpd_pkg::PH_PAYLOAD: begin
        first_valid             = 1'b1;
        first_item.payload_byte = b;
      end
      cpd_pkg::PH_CRC: begin
        if (idx_r != cpd_pkg::HDR_FIRST) begin
          first_valid          = 1'b1;
          first_item.out_kind  = cpd_pkg::KIND_STATUS;
          first_item.crc_match = ({b, crc_lo_r} == crc_r);
        end
      end
      default: ;
    endcase

    push.count = 2'd0;
    push.item0 = first_valid ? first_item : trunc_item;
    push.item1 = trunc_item;
    if (accept) begin
      push.count = {1'b0, first_valid} + {1'b0, trunc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cpd_pkg::PH_HEADER;
      idx_r    <= 3'd0;
      ctrl_r   <= 8'd0;
      len_r    <= 16'd0;
      seq_r    <= 16'd0;
      cmd_r    <= 8'd0;
      pcount_r <= 16'd0;
      crc_r    <= 16'd0;
      crc_lo_r <= 8'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      ctrl_r   <= ctrl_nxt;
      len_r    <= len_nxt;
      seq_r    <= seq_nxt;
      cmd_r    <= cmd_nxt;
      pcount_r <= pcount_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

// ===== rtl/cpd_out_queue.sv =====
// ----------------------------------------------------------------------------
// cpd_out_queue
// Small result queue that takes zero, one or two results per cycle and hands
// out one per cycle on a valid/ready channel.
// ----------------------------------------------------------------------------
module cpd_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cpd_pkg::push_t     push,
  output logic               space_two,
  output logic               out_valid,
  input  logic               out_ready,
  output cpd_pkg::out_item_t out_data
);

  cpd_pkg::out_item_t              mem [cpd_pkg::QUEUE_DEPTH];
  logic [cpd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cpd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cpd_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic [cpd_pkg::QPTR_W-1:0]      wr_ptr_p1;
  logic                            pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign space_two = (count_r <= cpd_pkg::QCNT_W'(cpd_pkg::QUEUE_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + cpd_pkg::QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + cpd_pkg::QPTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + cpd_pkg::QPTR_W'(pop);
    count_nxt  = count_r + cpd_pkg::QCNT_W'(push.count) - cpd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.item0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/crc16_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// crc16_packet_deframer
// Splits received datagrams into length-framed packets with a CRC-16/XMODEM
// trailer, emitting payload bytes, frame status and truncation results.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. The parser handles each byte in the
// cycle it is accepted and writes its results into a four-word output queue;
// a result word can be read out the cycle after its byte was accepted. Most
// bytes make zero or one result word, so with the output side always ready the
// block runs at one byte per cycle. A payload byte that also ends its datagram
// mid-frame makes two words, a payload word and a truncation word, and the
// single output port hands them out in turn. in_ready is high whenever the
// queue has room for two words, so backpressure on the output side holds the
// input off only once the queue is nearly full.
module crc16_packet_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cpd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cpd_pkg::out_item_t out_data
);

  logic           accept;
  cpd_pkg::push_t push;

  assign accept = in_valid && in_ready;

  cpd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .push    (push)
  );

  cpd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_two (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
